FILE: hw/rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg: shared types and codes for the generational handle allocator
// Item layouts, action and status codes, fixed field widths.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int SLOTS_DEF    = 256;
    localparam int ID_BITS      = 8;
    localparam int GEN_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int OWNER_BITS   = 16;
    localparam int FIRST_ID     = 1;

    localparam logic [OWNER_BITS-1:0] OWNER_RST = OWNER_BITS'(1);

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP  = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NULL = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [OWNER_BITS-1:0]   handle_owner;
        logic [ID_BITS-1:0]      handle_slot;
        logic [GEN_BITS-1:0]     handle_generation;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic [OWNER_BITS-1:0]   out_owner;
        logic [ID_BITS-1:0]      out_slot;
        logic [GEN_BITS-1:0]     out_generation;
        logic [PAYLOAD_BITS-1:0] out_payload;
    } t_rsp;

    typedef struct packed {
        logic [OWNER_BITS-1:0] owner_tag;
    } t_cfg;

    // slot table write controls
    typedef struct packed {
        logic occ_set;
        logic occ_clr;
        logic gen_we;
        logic pay_we;
    } t_tbl_ctl;

    // free list controls
    typedef struct packed {
        logic pop;
        logic push;
        logic fresh;
    } t_fl_ctl;

endpackage

FILE: hw/rtl/gha_chan_if.sv
// ----------------------------------------------------------------------------
// gha_chan_if: valid/ready channel
// Carries one item of type T per handshake.
// ----------------------------------------------------------------------------
interface gha_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/gha_slot_tbl.sv
// ----------------------------------------------------------------------------
// gha_slot_tbl: per-slot occupied bits, generations and payloads
// Occupied and generation-valid bits in flops, generation and payload in RAM.
// ----------------------------------------------------------------------------
module gha_slot_tbl #(
    parameter int SLOTS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(SLOTS)-1:0]         i_rd_id,
    input  gha_pkg::t_tbl_ctl                i_ctl,
    input  logic [$clog2(SLOTS)-1:0]         i_wr_id,
    input  logic [gha_pkg::GEN_BITS-1:0]     i_gen_wdata,
    input  logic [gha_pkg::PAYLOAD_BITS-1:0] i_pay_wdata,
    output logic                             o_occ,
    output logic [gha_pkg::GEN_BITS-1:0]     o_gen,
    output logic [gha_pkg::PAYLOAD_BITS-1:0] o_pay
);
    import gha_pkg::*;

    logic [SLOTS-1:0]    r_occ;
    logic [SLOTS-1:0]    r_gen_vld;
    logic                r_occ_q;
    logic                r_gen_vld_q;
    logic [GEN_BITS-1:0] gen_q;

    // flag reads are registered alongside the RAM reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_gen_vld   <= '0;
            r_occ_q     <= 1'b0;
            r_gen_vld_q <= 1'b0;
        end else begin
            if (i_ctl.occ_set) begin
                r_occ[i_wr_id] <= 1'b1;
            end
            if (i_ctl.occ_clr) begin
                r_occ[i_wr_id] <= 1'b0;
            end
            if (i_ctl.gen_we) begin
                r_gen_vld[i_wr_id] <= 1'b1;
            end
            r_occ_q     <= r_occ[i_rd_id];
            r_gen_vld_q <= r_gen_vld[i_rd_id];
        end
    end

    gha_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.gen_we),
        .i_waddr (i_wr_id),
        .i_wdata (i_gen_wdata),
        .i_raddr (i_rd_id),
        .o_rdata (gen_q)
    );

    gha_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.pay_we),
        .i_waddr (i_wr_id),
        .i_wdata (i_pay_wdata),
        .i_raddr (i_rd_id),
        .o_rdata (o_pay)
    );

    // a generation never written reads as zero
    assign o_occ = r_occ_q;
    assign o_gen = r_gen_vld_q ? gen_q : '0;
endmodule

FILE: hw/rtl/gha_free_list.sv
// ----------------------------------------------------------------------------
// gha_free_list: LIFO of released ids plus the fresh id counter
// Each stack entry keeps the id together with its current generation.
// ----------------------------------------------------------------------------
module gha_free_list #(
    parameter int SLOTS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gha_pkg::t_fl_ctl             i_ctl,
    input  logic [$clog2(SLOTS)-1:0]     i_push_id,
    input  logic [gha_pkg::GEN_BITS-1:0] i_push_gen,
    output logic                         o_have_free,
    output logic                         o_have_fresh,
    output logic [$clog2(SLOTS)-1:0]     o_top_id,
    output logic [gha_pkg::GEN_BITS-1:0] o_top_gen,
    output logic [$clog2(SLOTS)-1:0]     o_fresh_id
);
    import gha_pkg::*;

    localparam int ID_W  = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = ID_W + GEN_BITS;

    logic [CNT_W-1:0] r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0] r_next_fresh, n_next_fresh;
    logic [ID_W-1:0]  top_addr;
    logic [ENT_W-1:0] top_q;
    logic             push_we;

    // top of stack is read every cycle; the count only moves on a completed item
    assign top_addr = ID_W'(r_free_cnt - CNT_W'(1));
    assign push_we  = i_ctl.push && (r_free_cnt < CNT_W'(SLOTS));

    always_comb begin
        n_free_cnt   = r_free_cnt;
        n_next_fresh = r_next_fresh;
        if (i_ctl.pop) begin
            n_free_cnt = r_free_cnt - CNT_W'(1);
        end else if (push_we) begin
            n_free_cnt = r_free_cnt + CNT_W'(1);
        end
        if (i_ctl.fresh) begin
            n_next_fresh = r_next_fresh + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt   <= '0;
            r_next_fresh <= CNT_W'(FIRST_ID);
        end else begin
            r_free_cnt   <= n_free_cnt;
            r_next_fresh <= n_next_fresh;
        end
    end

    gha_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (ID_W'(r_free_cnt)),
        .i_wdata ({i_push_id, i_push_gen}),
        .i_raddr (top_addr),
        .o_rdata (top_q)
    );

    assign o_have_free  = (r_free_cnt != '0);
    assign o_have_fresh = (r_next_fresh < CNT_W'(SLOTS));
    assign o_top_id     = top_q[ENT_W-1:GEN_BITS];
    assign o_top_gen    = top_q[GEN_BITS-1:0];
    assign o_fresh_id   = ID_W'(r_next_fresh);
endmodule

FILE: hw/rtl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator: slot map with generational handles
// Allocate, release and lookup of owner/id/generation handles.
// ----------------------------------------------------------------------------
// Channels: i_req takes one request item (action, payload, handle fields),
// o_rsp returns exactly one result item per request, i_cfg writes owner_tag
// (always ready; write only while the block is idle).
// Timing: a request is accepted, then the slot and stack memories are read
// with registered read; in the next cycle the handle is checked, the tables
// are written back and the result register is loaded. A new request is
// accepted only after the previous one has left the execute state, since
// the slot memories are read and then written.
// Stalls: the result register holds an item until o_rsp is ready; a new
// request is accepted only when that register is empty or drains in the
// same cycle, so nothing is lost under back-pressure.
// Reset: owner_tag returns to 1, occupied and generation-valid bits are
// cleared in the reset cycle itself (no clearing pass), the free stack
// empties and fresh ids restart at 1.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
    parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gha_chan_if.sink   i_req,
    gha_chan_if.source o_rsp,
    gha_chan_if.sink   i_cfg
);
    import gha_pkg::*;

    localparam int ID_W = $clog2(SLOTS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                    r_state;
    t_req                    r_req;
    t_rsp                    r_rsp, n_rsp;
    logic                    r_rsp_vld;
    logic [OWNER_BITS-1:0]   r_owner;

    logic                    req_acc;
    logic [ID_W-1:0]         rd_id, ex_id, wr_id, nid;
    t_tbl_ctl                tbl_ctl;
    t_fl_ctl                 fl_ctl;
    logic                    tbl_occ;
    logic [GEN_BITS-1:0]     tbl_gen, gen_wdata, alloc_gen;
    logic [PAYLOAD_BITS-1:0] tbl_pay;
    logic                    fl_have_free, fl_have_fresh;
    logic [ID_W-1:0]         fl_top_id, fl_fresh_id;
    logic [GEN_BITS-1:0]     fl_top_gen;
    logic                    id_ok, hdl_ok;

    assign i_req.ready = (r_state == S_IDLE) && (!r_rsp_vld || o_rsp.ready);
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_rsp_vld;
    assign o_rsp.data  = r_rsp;

    // memory reads are issued straight from the incoming item
    assign rd_id = i_req.data.handle_slot[ID_W-1:0];
    assign ex_id = r_req.handle_slot[ID_W-1:0];

    assign id_ok  = (r_req.handle_slot != '0) && (32'(r_req.handle_slot) < 32'(SLOTS));
    assign hdl_ok = (r_req.handle_owner == r_owner) && id_ok && tbl_occ
                    && (tbl_gen == r_req.handle_generation);

    always_comb begin
        n_rsp        = '0;
        n_rsp.status = STAT_BAD;
        tbl_ctl      = '0;
        fl_ctl       = '0;
        wr_id        = ex_id;
        gen_wdata    = '0;
        nid          = '0;
        alloc_gen    = '0;
        case (r_req.action)
            ACT_ALLOC: begin
                if (r_req.payload == '0) begin
                    n_rsp.status = STAT_NULL;
                end else if (fl_have_free || fl_have_fresh) begin
                    if (fl_have_free) begin
                        nid        = fl_top_id;
                        alloc_gen  = fl_top_gen;
                        fl_ctl.pop = 1'b1;
                    end else begin
                        nid          = fl_fresh_id;
                        fl_ctl.fresh = 1'b1;
                    end
                    wr_id                = nid;
                    tbl_ctl.occ_set      = 1'b1;
                    tbl_ctl.pay_we       = 1'b1;
                    n_rsp.status         = STAT_OK;
                    n_rsp.out_owner      = r_owner;
                    n_rsp.out_slot       = ID_BITS'(nid);
                    n_rsp.out_generation = alloc_gen;
                end else begin
                    n_rsp.status = STAT_FULL;
                end
            end
            ACT_RELEASE: begin
                if (hdl_ok) begin
                    tbl_ctl.occ_clr = 1'b1;
                    tbl_ctl.gen_we  = 1'b1;
                    n_rsp.status    = STAT_OK;
                    // wrapping generation retires the slot: not pushed
                    if (&tbl_gen) begin
                        gen_wdata = '0;
                    end else begin
                        gen_wdata   = GEN_BITS'(tbl_gen + GEN_BITS'(1));
                        fl_ctl.push = 1'b1;
                    end
                end
            end
            ACT_LOOKUP: begin
                if (hdl_ok) begin
                    n_rsp.status      = STAT_OK;
                    n_rsp.out_payload = tbl_pay;
                end
            end
            default: begin
                n_rsp.status = STAT_BAD;
            end
        endcase
        if (r_state != S_EXEC) begin
            tbl_ctl = '0;
            fl_ctl  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rsp_vld <= 1'b0;
            r_owner   <= OWNER_RST;
        end else begin
            if (i_cfg.valid) begin
                r_owner <= i_cfg.data.owner_tag;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_EXEC) begin
                r_rsp_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req.data;
        end
        if (r_state == S_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    gha_slot_tbl #(.SLOTS(SLOTS)) u_slot_tbl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_id     (rd_id),
        .i_ctl       (tbl_ctl),
        .i_wr_id     (wr_id),
        .i_gen_wdata (gen_wdata),
        .i_pay_wdata (r_req.payload),
        .o_occ       (tbl_occ),
        .o_gen       (tbl_gen),
        .o_pay       (tbl_pay)
    );

    gha_free_list #(.SLOTS(SLOTS)) u_free_list (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (fl_ctl),
        .i_push_id    (ex_id),
        .i_push_gen   (gen_wdata),
        .o_have_free  (fl_have_free),
        .o_have_fresh (fl_have_fresh),
        .o_top_id     (fl_top_id),
        .o_top_gen    (fl_top_gen),
        .o_fresh_id   (fl_fresh_id)
    );

    // the result register is always empty when an item completes
    a_rsp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_rsp_vld)
        else $error("result register busy at completion");

    // every accepted item yields a result once it has passed the execute state
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> ##1 r_rsp_vld)
        else $error("accepted item produced no result");

    // a granted handle never carries the invalid id
    a_alloc_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_ctl.occ_set) |-> (nid != '0))
        else $error("allocate granted the invalid id");

    // the stack never pops and pushes, nor pops and takes a fresh id, for the same item
    a_fl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fl_ctl.pop && fl_ctl.push) && !(fl_ctl.pop && fl_ctl.fresh))
        else $error("conflicting free list controls");
endmodule
